[rtl/tif_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tif_pkg
// Shared types and constants of the height table interpolator: opcodes,
// controller states, and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tif_pkg;

   localparam int FRAC_BITS_DEF     = 8;
   localparam int TABLE_ENTRIES_DEF = 129;

   localparam int OPCODE_W  = 2;
   localparam int INDEX_W   = 8;
   localparam int VALUE_W   = 16;
   localparam int SPAN_W    = VALUE_W + 1;
   localparam int QUOT_BITS = 15;
   localparam int CNT_W     = 4;

   localparam logic signed [VALUE_W-1:0] PRES_MAX = 16'sd32767;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE = 2'd0,
      OP_FWD   = 2'd1,
      OP_INV   = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_F_RA,
      ST_F_RB,
      ST_F_MUL,
      ST_F_SUM,
      ST_I_SRCH,
      ST_I_CMP,
      ST_I_RLO,
      ST_I_RHI,
      ST_I_SPAN,
      ST_I_MUL,
      ST_I_NUM,
      ST_I_OVF,
      ST_I_DIV,
      ST_I_QOUT
   } state_type;

   typedef enum logic [1:0] {
      RD_LO,
      RD_LO1,
      RD_MID,
      RD_HI
   } rd_sel_type;

   typedef enum logic [2:0] {
      OUT_FWD,
      OUT_QUOT,
      OUT_ZERO,
      OUT_SAT,
      OUT_FAULT
   } out_sel_type;

   typedef struct packed {
      logic        wr;
      logic        ld_fwd;
      logic        ld_inv;
      rd_sel_type  rd_sel;
      logic        cap_a;
      logic        ld_fprod;
      logic        srch_step;
      logic        ld_span;
      logic        ld_iprod;
      logic        ld_num;
      logic        div_start;
      logic        div_step;
      logic        load_out;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic srch_done;
      logic span_zero;
      logic q_neg;
      logic q_sat;
      logic div_last;
      logic out_hold;
   } stat_type;

endpackage

[rtl/tif_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tif_ctrl
// Sequencer of the interpolator: accepts request words, steps the datapath
// through table reads, search, multiply and divide, and loads the response.
// ----------------------------------------------------------------------------
module tif_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic [tif_pkg::OPCODE_W-1:0]         req_opcode,
   output logic                                 req_stall,
   input  tif_pkg::stat_type                    stat,
   output tif_pkg::cmd_type                     cmd
);

   tif_pkg::state_type state_ff, state_in;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tif_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != tif_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.rd_sel    = tif_pkg::RD_LO;
      cmd.out_sel   = tif_pkg::OUT_FWD;
      unique case (state_ff)
         tif_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  tif_pkg::OP_WRITE: begin
                     cmd.wr = 1'b1;
                  end
                  tif_pkg::OP_FWD: begin
                     cmd.ld_fwd = 1'b1;
                     state_in   = tif_pkg::ST_F_RA;
                  end
                  tif_pkg::OP_INV: begin
                     cmd.ld_inv = 1'b1;
                     state_in   = tif_pkg::ST_I_SRCH;
                  end
                  default: begin
                     state_in = tif_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         tif_pkg::ST_F_RA: begin
            cmd.rd_sel = tif_pkg::RD_LO;
            state_in   = tif_pkg::ST_F_RB;
         end
         tif_pkg::ST_F_RB: begin
            cmd.rd_sel = tif_pkg::RD_LO1;
            cmd.cap_a  = 1'b1;
            state_in   = tif_pkg::ST_F_MUL;
         end
         tif_pkg::ST_F_MUL: begin
            cmd.ld_fprod = 1'b1;
            state_in     = tif_pkg::ST_F_SUM;
         end
         tif_pkg::ST_F_SUM: begin
            if (!stat.out_hold) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = tif_pkg::OUT_FWD;
               state_in     = tif_pkg::ST_IDLE;
            end
         end
         tif_pkg::ST_I_SRCH: begin
            if (stat.srch_done) begin
               state_in = tif_pkg::ST_I_RLO;
            end else begin
               cmd.rd_sel = tif_pkg::RD_MID;
               state_in   = tif_pkg::ST_I_CMP;
            end
         end
         tif_pkg::ST_I_CMP: begin
            cmd.srch_step = 1'b1;
            state_in      = tif_pkg::ST_I_SRCH;
         end
         tif_pkg::ST_I_RLO: begin
            cmd.rd_sel = tif_pkg::RD_LO;
            state_in   = tif_pkg::ST_I_RHI;
         end
         tif_pkg::ST_I_RHI: begin
            cmd.rd_sel = tif_pkg::RD_HI;
            cmd.cap_a  = 1'b1;
            state_in   = tif_pkg::ST_I_SPAN;
         end
         tif_pkg::ST_I_SPAN: begin
            cmd.ld_span = 1'b1;
            state_in    = tif_pkg::ST_I_MUL;
         end
         tif_pkg::ST_I_MUL: begin
            cmd.ld_iprod = 1'b1;
            state_in     = tif_pkg::ST_I_NUM;
         end
         tif_pkg::ST_I_NUM: begin
            cmd.ld_num = 1'b1;
            state_in   = tif_pkg::ST_I_OVF;
         end
         tif_pkg::ST_I_OVF: begin
            priority if (stat.span_zero) begin
               if (!stat.out_hold) begin
                  cmd.load_out = 1'b1;
                  cmd.out_sel  = tif_pkg::OUT_FAULT;
                  state_in     = tif_pkg::ST_IDLE;
               end
            end else if (stat.q_neg) begin
               if (!stat.out_hold) begin
                  cmd.load_out = 1'b1;
                  cmd.out_sel  = tif_pkg::OUT_ZERO;
                  state_in     = tif_pkg::ST_IDLE;
               end
            end else if (stat.q_sat) begin
               if (!stat.out_hold) begin
                  cmd.load_out = 1'b1;
                  cmd.out_sel  = tif_pkg::OUT_SAT;
                  state_in     = tif_pkg::ST_IDLE;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = tif_pkg::ST_I_DIV;
            end
         end
         tif_pkg::ST_I_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = tif_pkg::ST_I_QOUT;
            end
         end
         tif_pkg::ST_I_QOUT: begin
            if (!stat.out_hold) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = tif_pkg::OUT_QUOT;
               state_in     = tif_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tif_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/tif_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tif_dp
// Datapath of the interpolator: height table memory, search bounds,
// interpolation multiply, numerator build, restoring divider and the
// response register.
// ----------------------------------------------------------------------------
module tif_dp #(
   parameter int FRAC_BITS     = tif_pkg::FRAC_BITS_DEF,
   parameter int TABLE_ENTRIES = tif_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tif_pkg::cmd_type                     cmd,
   output tif_pkg::stat_type                    stat,
   input  logic [tif_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic signed [tif_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   output logic signed [tif_pkg::VALUE_W-1:0]   rsp_result,
   output logic                                 rsp_fault,
   input  logic                                 rsp_stall
);

   localparam int VW     = tif_pkg::VALUE_W;
   localparam int SW     = tif_pkg::SPAN_W;
   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int PART_W = FRAC_BITS + 1;
   localparam int FP_W   = SW + PART_W + 1;
   localparam int SUM_W  = FRAC_BITS + 20;
   localparam int IP_W   = IDX_W + 1 + SW;
   localparam int NUM_W  = IP_W + 2 + FRAC_BITS;
   localparam int DIV_W  = (NUM_W > 32) ? NUM_W : 32;
   localparam int QB     = tif_pkg::QUOT_BITS;

   localparam logic [15:0]             LAST_PAIR  = 16'(TABLE_ENTRIES - 2);
   localparam logic [IDX_W-1:0]        LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [PART_W-1:0]       STEP_SCALE = PART_W'(1) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0] HALF_STEP  = SUM_W'(1) <<< (FRAC_BITS - 1);

   logic signed [VW-1:0]     mem [TABLE_ENTRIES];
   logic signed [VW-1:0]     rd_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;

   logic [IDX_W-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [PART_W-1:0]        part_ff, part_in;
   logic signed [VW-1:0]     hgt_ff, a_ff;
   logic signed [FP_W-1:0]   fprod_ff;
   logic signed [SW-1:0]     span_ff, sub_ff;
   logic signed [IP_W-1:0]   iprod_ff;
   logic                     neg_ff;
   logic [DIV_W-1:0]         rem_ff, rem_in, dsh_ff;
   logic [SW-1:0]            dmag_ff;
   logic [QB-1:0]            q_ff;
   logic [tif_pkg::CNT_W-1:0] cnt_ff;
   logic                     out_valid_ff, out_valid_in;
   logic signed [VW-1:0]     out_result_ff, out_result_in;
   logic                     out_fault_ff, out_fault_in;

   logic [IDX_W:0]           mid_sum;
   logic [IDX_W-1:0]         mid;
   logic [14:0]              pres;
   logic [15:0]              fidx;
   logic signed [SW-1:0]     diff;
   logic signed [SUM_W-1:0]  fwd_sum;
   logic signed [IP_W:0]     psum;
   logic signed [NUM_W-1:0]  num;
   logic [NUM_W-1:0]         num_mag;
   logic [DIV_W:0]           trial;

   assign wr_en = cmd.wr && ({1'b0, req_entry_index} < 9'(TABLE_ENTRIES));

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_W:1];

   always_comb begin
      unique case (cmd.rd_sel)
         tif_pkg::RD_LO:  rd_addr = lo_ff;
         tif_pkg::RD_LO1: rd_addr = lo_ff + IDX_W'(1);
         tif_pkg::RD_MID: rd_addr = mid;
         tif_pkg::RD_HI:  rd_addr = hi_ff;
         default:         rd_addr = lo_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[req_entry_index[IDX_W-1:0]] <= req_value;
      end
      rd_ff <= mem[rd_addr];
   end

   assign pres = req_value[VW-1] ? 15'd0 : req_value[14:0];
   assign fidx = 16'(pres >> FRAC_BITS);

   always_comb begin
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      part_in = part_ff;
      if (cmd.ld_fwd) begin
         if (fidx > LAST_PAIR) begin
            lo_in   = LAST_PAIR[IDX_W-1:0];
            part_in = STEP_SCALE;
         end else begin
            lo_in   = fidx[IDX_W-1:0];
            part_in = {1'b0, pres[FRAC_BITS-1:0]};
         end
      end else if (cmd.ld_inv) begin
         lo_in = '0;
         hi_in = LAST_IDX;
      end else if (cmd.srch_step) begin
         if (rd_ff < hgt_ff) begin
            hi_in = mid;
         end else begin
            lo_in = mid;
         end
      end
   end

   assign diff    = SW'(rd_ff) - SW'(a_ff);
   assign fwd_sum = (SUM_W'(a_ff) <<< FRAC_BITS) + SUM_W'(fprod_ff) + HALF_STEP;

   assign psum    = (IP_W + 1)'(iprod_ff) + (IP_W + 1)'(sub_ff);
   assign num     = (NUM_W'(psum) <<< FRAC_BITS) + NUM_W'(span_ff >>> 1);
   assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

   assign trial   = {1'b0, rem_ff} - {1'b0, dsh_ff};

   always_comb begin
      rem_in = rem_ff;
      if (cmd.ld_num) begin
         rem_in = DIV_W'(num_mag);
      end else if (cmd.div_step && !trial[DIV_W]) begin
         rem_in = trial[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      part_ff <= part_in;
      rem_ff  <= rem_in;
      if (cmd.ld_inv) begin
         hgt_ff <= req_value;
      end
      if (cmd.cap_a) begin
         a_ff <= rd_ff;
      end
      if (cmd.ld_fprod) begin
         fprod_ff <= diff * $signed({1'b0, part_ff});
      end
      if (cmd.ld_span) begin
         span_ff <= SW'(a_ff) - SW'(rd_ff);
         sub_ff  <= SW'(a_ff) - SW'(hgt_ff);
      end
      if (cmd.ld_iprod) begin
         iprod_ff <= $signed({1'b0, lo_ff}) * span_ff;
      end
      if (cmd.ld_num) begin
         neg_ff  <= num[NUM_W-1] ^ span_ff[SW-1];
         dmag_ff <= span_ff[SW-1] ? SW'(-span_ff) : SW'(span_ff);
      end
      if (cmd.div_start) begin
         dsh_ff <= DIV_W'(dmag_ff) << (QB - 1);
         q_ff   <= '0;
         cnt_ff <= tif_pkg::CNT_W'(QB - 1);
      end else if (cmd.div_step) begin
         dsh_ff <= dsh_ff >> 1;
         q_ff   <= {q_ff[QB-2:0], !trial[DIV_W]};
         cnt_ff <= cnt_ff - tif_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      out_result_in = out_result_ff;
      out_fault_in  = out_fault_ff;
      if (cmd.load_out) begin
         unique case (cmd.out_sel)
            tif_pkg::OUT_FWD: begin
               out_result_in = fwd_sum[FRAC_BITS +: VW];
               out_fault_in  = 1'b0;
            end
            tif_pkg::OUT_QUOT: begin
               out_result_in = $signed({1'b0, q_ff});
               out_fault_in  = 1'b0;
            end
            tif_pkg::OUT_ZERO: begin
               out_result_in = '0;
               out_fault_in  = 1'b0;
            end
            tif_pkg::OUT_SAT: begin
               out_result_in = tif_pkg::PRES_MAX;
               out_fault_in  = 1'b0;
            end
            tif_pkg::OUT_FAULT: begin
               out_result_in = '0;
               out_fault_in  = 1'b1;
            end
            default: begin
               out_result_in = '0;
               out_fault_in  = 1'b0;
            end
         endcase
      end
   end

   assign out_valid_in = cmd.load_out || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_result_ff <= out_result_in;
      out_fault_ff  <= out_fault_in;
   end

   assign stat.srch_done = ({1'b0, hi_ff} == ({1'b0, lo_ff} + (IDX_W + 1)'(1)));
   assign stat.span_zero = (span_ff == '0);
   assign stat.q_neg     = neg_ff;
   assign stat.q_sat     = (rem_ff >= (DIV_W'(dmag_ff) << QB));
   assign stat.div_last  = (cnt_ff == '0);
   assign stat.out_hold  = out_valid_ff && rsp_stall;

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_result_ff;
   assign rsp_fault  = out_fault_ff;

endmodule

[rtl/table_interpolator_forward_inverse_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_interpolator_forward_inverse_unit
// Piecewise-linear height table with forward (pressure to height) and
// inverse (height to pressure) lookup.
// ----------------------------------------------------------------------------
// One request word is worked at a time. A table write returns nothing. A
// forward lookup reads the table memory twice through its single read port,
// then does one multiply and the rounding sum. An inverse lookup probes the
// table memory in a binary search, each probe a read and then a compare,
// then does two reads, the numerator build and a 15-step restoring divider;
// zero-span, negative and saturated cases skip the divider. The response
// sits in an output register, so the next request is taken while it waits;
// an entry must be written before any lookup reads it.
// ----------------------------------------------------------------------------
module table_interpolator_forward_inverse_unit #(
   parameter int FRAC_BITS     = tif_pkg::FRAC_BITS_DEF,
   parameter int TABLE_ENTRIES = tif_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tif_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic [tif_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic signed [tif_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tif_pkg::VALUE_W-1:0]   rsp_result,
   output logic                                 rsp_fault
);

   tif_pkg::cmd_type  cmd;
   tif_pkg::stat_type stat;

   tif_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   tif_dp #(
      .FRAC_BITS     (FRAC_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_entry_index (req_entry_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_result      (rsp_result),
      .rsp_fault       (rsp_fault),
      .rsp_stall       (rsp_stall)
   );

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_valid && rsp_stall))
      else $error("response word overwritten while stalled");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fault) |-> (rsp_result == '0))
      else $error("fault word with nonzero result");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == tif_pkg::OP_WRITE) |=> !cmd.load_out)
      else $error("table write produced a response word");
`endif

endmodule

[verif/tif_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tif_result_checker
// Watches both channels of the height table interpolator. Keeps its own copy
// of the height table, works out the response of every accepted lookup word
// and compares each accepted response, in order, with the oldest one due.
// Reports the number of failures and the number of responses still due.
// ----------------------------------------------------------------------------
module tif_result_checker #(
   parameter int FRAC_BITS     = tif_pkg::FRAC_BITS_DEF,
   parameter int TABLE_ENTRIES = tif_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [tif_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic [tif_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic signed [tif_pkg::VALUE_W-1:0]   req_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [tif_pkg::VALUE_W-1:0]   rsp_result,
   input  logic                                 rsp_fault,
   output int                                   fail_count,
   output int                                   pending_count
);
   import tif_pkg::*;

   localparam int STEP       = 1 << FRAC_BITS;
   localparam int REPORT_CAP = 200;

   typedef struct {
      logic signed [VALUE_W-1:0] result;
      logic                      fault;
   } lookup_word_t;

   logic signed [VALUE_W-1:0] heights [TABLE_ENTRIES];
   lookup_word_t              due_lookups [$];
   int                        errors = 0;

   function automatic logic signed [VALUE_W-1:0] pres_to_height(
      input logic signed [VALUE_W-1:0] pres
   );
      int     p;
      int     idx;
      int     part;
      longint acc;
      p = pres;
      if (p < 0) p = 0;
      idx  = p >>> FRAC_BITS;
      part = p & (STEP - 1);
      if (idx > TABLE_ENTRIES - 2) begin
         idx  = TABLE_ENTRIES - 2;
         part = STEP;
      end
      acc = longint'(heights[idx]) * (STEP - part)
          + longint'(heights[idx + 1]) * part + (STEP >> 1);
      return VALUE_W'(acc >>> FRAC_BITS);
   endfunction

   function automatic void height_to_pres(
      input  logic signed [VALUE_W-1:0] hgt,
      output logic signed [VALUE_W-1:0] pres,
      output logic                      flt
   );
      int     lo;
      int     hi;
      int     mid;
      longint span;
      longint sub;
      longint num;
      longint half;
      longint q;
      lo   = 0;
      hi   = TABLE_ENTRIES - 1;
      pres = '0;
      flt  = 1'b0;
      while (hi - lo != 1) begin
         mid = (lo + hi) >> 1;
         if (heights[mid] < hgt) hi = mid;
         else lo = mid;
      end
      span = longint'(heights[lo]) - longint'(heights[hi]);
      sub  = longint'(heights[lo]) - longint'(hgt);
      if (span == 0) begin
         flt = 1'b1;
         return;
      end
      num  = (longint'(lo) * (span - sub) + longint'(hi) * sub) * STEP;
      half = (span >= 0) ? span / 2 : -((-span + 1) / 2);
      q    = (num + half) / span;
      if (q > longint'(PRES_MAX)) q = longint'(PRES_MAX);
      if (q < 0) q = 0;
      pres = VALUE_W'(q);
   endfunction

   task automatic flag_mismatch(input string field, input int want, input int got);
      if (errors < REPORT_CAP)
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      lookup_word_t want;
      if (reset) begin
         due_lookups.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_lookups.size() == 0) begin
               if (errors < REPORT_CAP)
                  $error("response with none due: result %0d fault %0b",
                         rsp_result, rsp_fault);
               errors++;
            end else begin
               want = due_lookups.pop_front();
               if (rsp_result !== want.result) flag_mismatch("result", want.result, rsp_result);
               if (rsp_fault !== want.fault) flag_mismatch("fault", want.fault, rsp_fault);
            end
         end
         if (req_valid && !req_stall) begin
            case (req_opcode)
               OP_WRITE: begin
                  if (req_entry_index < TABLE_ENTRIES) heights[req_entry_index] = req_value;
               end
               OP_FWD: begin
                  want.result = pres_to_height(req_value);
                  want.fault  = 1'b0;
                  due_lookups.push_back(want);
               end
               OP_INV: begin
                  height_to_pres(req_value, want.result, want.fault);
                  due_lookups.push_back(want);
               end
               default: begin
               end
            endcase
         end
      end
      fail_count    <= errors;
      pending_count <= due_lookups.size();
   end

endmodule

[verif/tb_table_interpolator_forward_inverse_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_table_interpolator_forward_inverse_unit
// Loads height tables of several shapes (steady descent over the full range,
// flat runs, gentle slopes, scrambled) and fires forward and inverse lookups,
// sparse table rewrites and unused opcodes at the unit, with phases of sender
// gaps and receiver stalls, long receiver hold-offs and drain pauses.
// A side checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_table_interpolator_forward_inverse_unit;
   import tif_pkg::*;

   localparam int FRAC_BITS       = FRAC_BITS_DEF;
   localparam int ENTRIES         = TABLE_ENTRIES_DEF;
   localparam int STEP            = 1 << FRAC_BITS;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT     = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 60;
   localparam int ROUNDS          = 8;
   localparam int ROUND_WORDS     = 170;

   typedef enum int {
      SHAPE_DESCENDING,
      SHAPE_PLATEAU,
      SHAPE_SCRAMBLED,
      SHAPE_GENTLE
   } table_shape_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OPCODE_W-1:0]       req_opcode = OP_WRITE;
   logic [INDEX_W-1:0]        req_entry_index = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_result;
   logic                      rsp_fault;

   int                        fail_count;
   int                        pending_count;
   int                        tx_idle_pct = 0;
   int                        rx_stall_pct = 0;
   bit                        hold_request = 1'b0;
   int                        quiet_cycles = 0;
   logic signed [VALUE_W-1:0] shadow [ENTRIES];

   table_interpolator_forward_inverse_unit #(
      .FRAC_BITS     (FRAC_BITS),
      .TABLE_ENTRIES (ENTRIES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_fault       (rsp_fault)
   );

   tif_result_checker #(
      .FRAC_BITS     (FRAC_BITS),
      .TABLE_ENTRIES (ENTRIES)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_fault       (rsp_fault),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : rsp_driver
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic signed [VALUE_W-1:0] val);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_value       <= val;
      if (op == OP_WRITE && idx < ENTRIES) shadow[idx] = val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic fill_table(input table_shape_t shape);
      int h;
      int i;
      case (shape)
         SHAPE_DESCENDING: h = 32767;
         SHAPE_PLATEAU:    h = $urandom_range(20000);
         SHAPE_GENTLE:     h = int'($urandom_range(400)) - 200;
         default:          h = 0;
      endcase
      for (i = 0; i < ENTRIES; i++) begin
         if (shape == SHAPE_SCRAMBLED) h = int'(VALUE_W'($urandom)) - 32768;
         send_word(OP_WRITE, INDEX_W'(i), VALUE_W'(h));
         case (shape)
            SHAPE_DESCENDING: h -= $urandom_range(400, 620);
            SHAPE_PLATEAU:    h -= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 300);
            SHAPE_GENTLE:     h -= $urandom_range(3);
            default: begin
            end
         endcase
         if (h < -32768) h = -32768;
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_height();
      int k;
      int a;
      int b;
      k = $urandom_range(ENTRIES - 2);
      a = shadow[k];
      b = shadow[k + 1];
      case ($urandom_range(3))
         0: return shadow[k];
         1: return VALUE_W'(a + int'($urandom_range(6)) - 3);
         2: begin
            if (a < b) return VALUE_W'(a + int'($urandom_range(b - a)));
            return VALUE_W'(b + int'($urandom_range(a - b)));
         end
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_pressure();
      case ($urandom_range(3))
         0: return VALUE_W'($urandom_range(32767));
         1: return VALUE_W'($urandom_range(ENTRIES - 1) * STEP + $urandom_range(2));
         2: return VALUE_W'($urandom);
         default: return VALUE_W'(32767 - $urandom_range(300));
      endcase
   endfunction

   task automatic random_word();
      int r;
      int idx;
      r = $urandom_range(99);
      if (r < 42) begin
         send_word(OP_FWD, INDEX_W'($urandom), pick_pressure());
      end else if (r < 84) begin
         send_word(OP_INV, INDEX_W'($urandom), pick_height());
      end else if (r < 95) begin
         idx = ($urandom_range(9) < 7) ? $urandom_range(ENTRIES - 1) : $urandom_range(255);
         if (idx < ENTRIES && $urandom_range(1) == 0)
            send_word(OP_WRITE, INDEX_W'(idx),
                      VALUE_W'(int'(shadow[idx]) + int'($urandom_range(20)) - 10));
         else
            send_word(OP_WRITE, INDEX_W'(idx), VALUE_W'($urandom));
      end else begin
         send_word(OP_UNUSED, INDEX_W'($urandom), VALUE_W'($urandom));
      end
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fill_table(SHAPE_DESCENDING);
      send_word(OP_FWD, 8'd0, -16'sd32768);
      send_word(OP_FWD, 8'd255, -16'sd1);
      send_word(OP_FWD, 8'd0, 16'sd0);
      send_word(OP_FWD, 8'd0, 16'sd1);
      send_word(OP_FWD, 8'd0, VALUE_W'(STEP - 1));
      send_word(OP_FWD, 8'd0, VALUE_W'(STEP));
      send_word(OP_FWD, 8'd0, 16'sd32767);
      send_word(OP_INV, 8'd0, 16'sd32767);
      send_word(OP_INV, 8'd0, -16'sd32768);
      send_word(OP_INV, 8'd0, shadow[0]);
      send_word(OP_INV, 8'd0, shadow[ENTRIES - 1]);
      send_word(OP_INV, 8'd0, shadow[64]);
      send_word(OP_INV, 8'd0, VALUE_W'((int'(shadow[10]) + int'(shadow[11])) / 2));
      send_word(OP_WRITE, INDEX_W'(ENTRIES - 2), shadow[ENTRIES - 1]);
      send_word(OP_INV, 8'd0, -16'sd32768);
      send_word(OP_WRITE, 8'd0, 16'sd20000);
      send_word(OP_WRITE, 8'd1, 16'sd20000);
      send_word(OP_INV, 8'd0, 16'sd32767);
      send_word(OP_WRITE, INDEX_W'(ENTRIES), 16'sd12345);
      send_word(OP_WRITE, 8'd255, -16'sd1);
      send_word(OP_UNUSED, 8'd255, -16'sd1);
      drain();

      for (int r = 0; r < ROUNDS; r++) begin
         case (r % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
            default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
         endcase
         if (r % 2 == 0) fill_table(table_shape_t'((r / 2) % 4));
         for (int n = 0; n < ROUND_WORDS; n++) begin
            if (r % 4 == 0 && n == 20) hold_request = 1'b1;
            random_word();
         end
         drain();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/tif_pkg.sv
rtl/tif_ctrl.sv
rtl/tif_dp.sv
rtl/table_interpolator_forward_inverse_unit.sv
verif/tif_result_checker.sv
verif/tb_table_interpolator_forward_inverse_unit.sv
